/* hdl/vertex_normal_accumulator_macros.svh */
// ----------------------------------------------------------------------------
// Vertex normal accumulator assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef VERTEX_NORMAL_ACCUMULATOR_MACROS_SVH
`define VERTEX_NORMAL_ACCUMULATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define VNA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vna assertion failed");

// next-cycle implication, disabled during reset
`define VNA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vna assertion failed");

`endif

/* hdl/vna_pkg.sv */
// ----------------------------------------------------------------------------
// Vertex normal accumulator package
// Widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vna_pkg;

    // parameter defaults
    localparam int MAX_PAIRS_DEF  = 16;
    localparam int COORD_BITS_DEF = 24;

    // fixed field and arithmetic widths
    localparam int COORD_W   = 24;
    localparam int N_COORDS  = 9;
    localparam int IN_DATA_W = COORD_W * N_COORDS;
    localparam int EDGE_W    = 25;
    localparam int CROSS_W   = 51;
    localparam int SUM_W     = 56;
    localparam int EPS_W     = 40;
    localparam int OUT_W     = 16;
    localparam int OUT_DATA_W = 3 * OUT_W;
    localparam int OPND_W    = 33;
    localparam int PROD_W    = 2 * OPND_W;
    localparam int ACC_W     = PROD_W + 1;
    localparam int SQ_W      = 20;
    localparam int CHK_W     = 42;
    localparam int T_W       = 31;
    localparam int RN_W      = 64;
    localparam int ROOT_W    = 32;
    localparam int NUM_W     = 48;
    localparam int QUO_W     = 16;
    localparam int REM_W     = 34;
    localparam int RAW_SHIFT = 10;
    localparam int CFG_IDX_W = 1;
    localparam int STEP_W    = 5;

    // sequencing counts
    localparam int AXES        = 3;
    localparam int CROSS_TERMS = 6;
    localparam int ROOT_STEPS  = RN_W / 2;

    localparam logic [14:0] Q14_ONE = 15'd16384;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FACE_EPS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUM_EPS  = 1'b1;

    // datapath operations
    typedef enum logic [4:0] {
        DP_NOP, DP_LOAD, DP_MUL, DP_ADD, DP_STC, DP_ORIENT, DP_ACCUM, DP_LOAD_T,
        DP_RAW, DP_SHR, DP_SHL, DP_SQINIT, DP_SQSTEP, DP_DINIT, DP_DSTEP,
        DP_DSTORE, DP_EMIT
    } t_dp_op;

    // multiplier operand pairs; the six cross terms come first, in order
    typedef enum logic [3:0] {
        MOP_CX_P, MOP_CX_N, MOP_CY_P, MOP_CY_N, MOP_CZ_P, MOP_CZ_N,
        MOP_CSQ, MOP_SSQ, MOP_TSQ
    } t_mop;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISP, ST_MUL, ST_ADD, ST_STC, ST_ORIENT, ST_FMUL, ST_FADD,
        ST_ACCUM, ST_SMUL, ST_SADD, ST_SDEC, ST_SHIFT, ST_TMUL, ST_TADD,
        ST_SQINIT, ST_SQRT, ST_DINIT, ST_DIV, ST_DSTORE, ST_EMIT
    } t_state;

    typedef struct packed {
        t_dp_op     op;
        t_mop       mop;
        logic [1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic pair_valid;
        logic last_pair;
        logic count_ok;
        logic sum_exc;
        logic t_hi;
        logic t_lo;
        logic out_full;
    } t_status;

endpackage

`default_nettype wire

/* hdl/vertex_normal_accumulator.sv */
// Vertex normal accumulator.
// Input stream: one transaction per adjacent-triangle pair of a vertex. tdata
// carries center, first and second neighbor (x, y, z each, Q12.12), tuser[0]
// says the transaction carries a real pair, tlast closes the vertex.
// Output stream: one transaction per vertex (on tlast): the normal in Q1.14
// and tuser[0] = 1 when it was scaled to unit length, 0 for a degenerate sum.
// Configuration: write port, index 0 = face threshold, 1 = sum threshold.
// Sequencing: one shared 33x33 multiplier sequenced by a controller. No new
// pair is taken until the block is through with the last one. A closing
// transaction adds the sum test and, above the sum threshold, up to 30 shifts
// of normalization, squares, a 32-step square root and three 16-step divides.
// The result sits in an output register; new pairs are taken while it waits,
// and only the next emit stalls while the receiver holds tready low.
// Reset clears the thresholds, running sums, pair count and the output valid.
// ----------------------------------------------------------------------------
// Vertex normal accumulator top level
// Connects the controller and the datapath to the stream and config ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vertex_normal_accumulator #(
    parameter int MAX_PAIRS  = vna_pkg::MAX_PAIRS_DEF,
    parameter int COORD_BITS = vna_pkg::COORD_BITS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // center_x/y/z, first_nb_x/y/z, second_nb_x/y/z, 24 bits each
    input  wire  [vna_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    // pair_valid
    input  wire  [0:0]                           s_axis_tuser,
    input  wire                                  s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // normal_x, normal_y, normal_z, 16 bits each
    output logic [vna_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // normalized
    output logic [0:0]                           m_axis_tuser,
    input  wire                                  i_cfg_we,
    input  wire  [vna_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire  [vna_pkg::EPS_W-1:0]            i_cfg_data
);

    vna_pkg::t_cmd    w_cmd;
    vna_pkg::t_status w_status;

    vna_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (w_status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    vna_datapath #(
        .MAX_PAIRS  (MAX_PAIRS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_in_data       (s_axis_tdata),
        .i_in_pair_valid (s_axis_tuser[0]),
        .i_in_last       (s_axis_tlast),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_m_ready       (m_axis_tready),
        .o_m_valid       (m_axis_tvalid),
        .o_m_data        (m_axis_tdata),
        .o_m_normalized  (m_axis_tuser[0]),
        .o_status        (w_status)
    );

endmodule

`default_nettype wire

/* hdl/vna_ctrl.sv */
// ----------------------------------------------------------------------------
// Vertex normal accumulator controller
// Sequences cross products, face test, sum test, normalization, root, divides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vna_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  vna_pkg::t_status    i_status,
    output logic                o_in_ready,
    output vna_pkg::t_cmd       o_cmd
);

    vna_pkg::t_state                  r_state, n_state;
    logic [vna_pkg::STEP_W-1:0]       r_cnt, n_cnt;
    logic [1:0]                       r_idx, n_idx;
    logic                             w_accept;

    assign w_accept = i_in_valid & (r_state == vna_pkg::ST_IDLE);

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vna_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        unique case (r_state)
            vna_pkg::ST_IDLE: begin
                if (w_accept) n_state = vna_pkg::ST_DISP;
            end
            vna_pkg::ST_DISP: begin
                n_cnt = '0;
                priority if (i_status.pair_valid && i_status.count_ok)
                    n_state = vna_pkg::ST_MUL;
                else if (i_status.last_pair)
                    n_state = vna_pkg::ST_SMUL;
                else
                    n_state = vna_pkg::ST_IDLE;
            end
            vna_pkg::ST_MUL: n_state = vna_pkg::ST_ADD;
            vna_pkg::ST_ADD: begin
                if (r_cnt[0]) begin
                    n_state = vna_pkg::ST_STC;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = vna_pkg::ST_MUL;
                end
            end
            vna_pkg::ST_STC: begin
                if (r_cnt == vna_pkg::STEP_W'(vna_pkg::CROSS_TERMS - 1)) begin
                    n_cnt   = '0;
                    n_state = vna_pkg::ST_ORIENT;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = vna_pkg::ST_MUL;
                end
            end
            vna_pkg::ST_ORIENT: n_state = vna_pkg::ST_FMUL;
            vna_pkg::ST_FMUL:   n_state = vna_pkg::ST_FADD;
            vna_pkg::ST_FADD: begin
                if (r_cnt == vna_pkg::STEP_W'(vna_pkg::AXES - 1)) begin
                    n_state = vna_pkg::ST_ACCUM;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = vna_pkg::ST_FMUL;
                end
            end
            vna_pkg::ST_ACCUM: begin
                n_cnt   = '0;
                n_state = i_status.last_pair ? vna_pkg::ST_SMUL : vna_pkg::ST_IDLE;
            end
            vna_pkg::ST_SMUL: n_state = vna_pkg::ST_SADD;
            vna_pkg::ST_SADD: begin
                if (r_cnt == vna_pkg::STEP_W'(vna_pkg::AXES - 1)) begin
                    n_state = vna_pkg::ST_SDEC;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = vna_pkg::ST_SMUL;
                end
            end
            vna_pkg::ST_SDEC: begin
                n_state = i_status.sum_exc ? vna_pkg::ST_SHIFT : vna_pkg::ST_EMIT;
            end
            vna_pkg::ST_SHIFT: begin
                n_cnt = '0;
                if (!i_status.t_hi && !i_status.t_lo) n_state = vna_pkg::ST_TMUL;
            end
            vna_pkg::ST_TMUL: n_state = vna_pkg::ST_TADD;
            vna_pkg::ST_TADD: begin
                if (r_cnt == vna_pkg::STEP_W'(vna_pkg::AXES - 1)) begin
                    n_state = vna_pkg::ST_SQINIT;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = vna_pkg::ST_TMUL;
                end
            end
            vna_pkg::ST_SQINIT: begin
                n_cnt   = '0;
                n_state = vna_pkg::ST_SQRT;
            end
            vna_pkg::ST_SQRT: begin
                if (r_cnt == vna_pkg::STEP_W'(vna_pkg::ROOT_STEPS - 1)) begin
                    n_idx   = '0;
                    n_state = vna_pkg::ST_DINIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            vna_pkg::ST_DINIT: begin
                n_cnt   = '0;
                n_state = vna_pkg::ST_DIV;
            end
            vna_pkg::ST_DIV: begin
                if (r_cnt == vna_pkg::STEP_W'(vna_pkg::QUO_W - 1))
                    n_state = vna_pkg::ST_DSTORE;
                else
                    n_cnt = r_cnt + 1'b1;
            end
            vna_pkg::ST_DSTORE: begin
                if (r_idx == 2'(vna_pkg::AXES - 1)) begin
                    n_state = vna_pkg::ST_EMIT;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = vna_pkg::ST_DINIT;
                end
            end
            vna_pkg::ST_EMIT: begin
                if (!i_status.out_full) n_state = vna_pkg::ST_IDLE;
            end
            default: n_state = vna_pkg::ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd.op   = vna_pkg::DP_NOP;
        o_cmd.mop  = vna_pkg::MOP_CSQ;
        o_cmd.idx  = r_cnt[1:0];
        unique case (r_state)
            vna_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (w_accept) o_cmd.op = vna_pkg::DP_LOAD;
            end
            vna_pkg::ST_MUL: begin
                o_cmd.op  = vna_pkg::DP_MUL;
                o_cmd.mop = vna_pkg::t_mop'({1'b0, r_cnt[2:0]});
            end
            vna_pkg::ST_ADD, vna_pkg::ST_FADD, vna_pkg::ST_SADD, vna_pkg::ST_TADD: begin
                o_cmd.op = vna_pkg::DP_ADD;
            end
            vna_pkg::ST_STC: begin
                o_cmd.op  = vna_pkg::DP_STC;
                o_cmd.idx = r_cnt[2:1];
            end
            vna_pkg::ST_ORIENT: o_cmd.op = vna_pkg::DP_ORIENT;
            vna_pkg::ST_FMUL: begin
                o_cmd.op  = vna_pkg::DP_MUL;
                o_cmd.mop = vna_pkg::MOP_CSQ;
            end
            vna_pkg::ST_ACCUM: o_cmd.op = vna_pkg::DP_ACCUM;
            vna_pkg::ST_SMUL: begin
                o_cmd.op  = vna_pkg::DP_MUL;
                o_cmd.mop = vna_pkg::MOP_SSQ;
            end
            vna_pkg::ST_SDEC: begin
                o_cmd.op = i_status.sum_exc ? vna_pkg::DP_LOAD_T : vna_pkg::DP_RAW;
            end
            vna_pkg::ST_SHIFT: begin
                priority if (i_status.t_hi) o_cmd.op = vna_pkg::DP_SHR;
                else if (i_status.t_lo)     o_cmd.op = vna_pkg::DP_SHL;
                else                        o_cmd.op = vna_pkg::DP_NOP;
            end
            vna_pkg::ST_TMUL: begin
                o_cmd.op  = vna_pkg::DP_MUL;
                o_cmd.mop = vna_pkg::MOP_TSQ;
            end
            vna_pkg::ST_SQINIT: o_cmd.op = vna_pkg::DP_SQINIT;
            vna_pkg::ST_SQRT:   o_cmd.op = vna_pkg::DP_SQSTEP;
            vna_pkg::ST_DINIT: begin
                o_cmd.op  = vna_pkg::DP_DINIT;
                o_cmd.idx = r_idx;
            end
            vna_pkg::ST_DIV: o_cmd.op = vna_pkg::DP_DSTEP;
            vna_pkg::ST_DSTORE: begin
                o_cmd.op  = vna_pkg::DP_DSTORE;
                o_cmd.idx = r_idx;
            end
            vna_pkg::ST_EMIT: begin
                if (!i_status.out_full) o_cmd.op = vna_pkg::DP_EMIT;
            end
            default: o_cmd.op = vna_pkg::DP_NOP;
        endcase
    end

endmodule

`default_nettype wire

/* hdl/vna_datapath.sv */
// ----------------------------------------------------------------------------
// Vertex normal accumulator datapath
// Shared multiplier/accumulator, running sums, shifter, root and divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vna_datapath #(
    parameter int MAX_PAIRS  = vna_pkg::MAX_PAIRS_DEF,
    parameter int COORD_BITS = vna_pkg::COORD_BITS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  vna_pkg::t_cmd                        i_cmd,
    input  wire  [vna_pkg::IN_DATA_W-1:0]        i_in_data,
    input  wire                                  i_in_pair_valid,
    input  wire                                  i_in_last,
    input  wire                                  i_cfg_we,
    input  wire  [vna_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire  [vna_pkg::EPS_W-1:0]            i_cfg_data,
    input  wire                                  i_m_ready,
    output logic                                 o_m_valid,
    output logic [vna_pkg::OUT_DATA_W-1:0]       o_m_data,
    output logic                                 o_m_normalized,
    output vna_pkg::t_status                     o_status
);

    localparam int CNT_W = $clog2(MAX_PAIRS + 1);
    localparam int CB    = (COORD_BITS < vna_pkg::COORD_W) ? COORD_BITS : vna_pkg::COORD_W;
    localparam bit SX    = (COORD_BITS <= vna_pkg::COORD_W);
    localparam int SH_W  = vna_pkg::SUM_W - vna_pkg::RAW_SHIFT;

    // coordinate field to signed edge-width value
    function automatic logic signed [vna_pkg::EDGE_W-1:0] f_coord(
        input logic [vna_pkg::COORD_W-1:0] raw
    );
        logic signed [vna_pkg::EDGE_W-1:0] v;
        v = '0;
        for (int b = 0; b < vna_pkg::EDGE_W; b++) begin
            if (b < CB)  v[b] = raw[b];
            else if (SX) v[b] = raw[CB-1];
            else         v[b] = 1'b0;
        end
        return v;
    endfunction

    function automatic logic [vna_pkg::OUT_W-1:0] f_signed_out(
        input logic neg, input logic [14:0] m
    );
        logic [vna_pkg::OUT_W-1:0] v;
        v = {1'b0, m};
        return neg ? -v : v;
    endfunction

    logic [vna_pkg::EPS_W-1:0]               r_face_eps, r_sum_eps;
    logic signed [vna_pkg::EDGE_W-1:0]       r_ea [3];
    logic signed [vna_pkg::EDGE_W-1:0]       r_eb [3];
    logic                                    r_pv, r_last;
    logic signed [vna_pkg::PROD_W-1:0]       r_prod;
    logic signed [vna_pkg::ACC_W-1:0]        r_acc;
    logic signed [vna_pkg::CROSS_W-1:0]      r_c [3];
    logic signed [vna_pkg::SUM_W-1:0]        r_sum [3];
    logic [CNT_W-1:0]                        r_count;
    logic [vna_pkg::SUM_W-1:0]               r_t [3];
    logic [vna_pkg::RN_W-1:0]                r_sn, r_res, r_bit;
    logic [vna_pkg::REM_W-1:0]               r_rem;
    logic [vna_pkg::QUO_W-1:0]               r_dn, r_quo;
    logic [14:0]                             r_q [3];
    logic                                    r_nrm;
    logic                                    r_out_valid;
    logic [vna_pkg::OUT_DATA_W-1:0]          r_out_data;
    logic                                    r_out_nrm;

    logic signed [vna_pkg::EDGE_W-1:0]       w_center [3];
    logic signed [vna_pkg::EDGE_W-1:0]       w_first [3];
    logic signed [vna_pkg::EDGE_W-1:0]       w_second [3];
    logic [vna_pkg::CROSS_W-1:0]             w_cmag [3];
    logic [vna_pkg::SUM_W-1:0]               w_smag [3];
    logic                                    w_cbig, w_sbig;
    logic                                    w_face_exc, w_sum_exc;
    logic                                    w_t_hi, w_t_lo;
    logic signed [vna_pkg::OPND_W-1:0]       w_opa, w_opb;
    logic [vna_pkg::RN_W-1:0]                w_trial;
    logic [vna_pkg::ROOT_W-1:0]              w_root;
    logic [vna_pkg::NUM_W-1:0]               w_num;
    logic [vna_pkg::REM_W:0]                 w_rem2, w_div;
    logic [14:0]                             w_raw_m [3];
    logic [SH_W-1:0]                         w_sh [3];
    logic                                    w_m_accept;

    // input unpacking, magnitudes and range flags
    always_comb begin
        w_cbig = 1'b0;
        w_sbig = 1'b0;
        w_t_hi = 1'b0;
        w_t_lo = 1'b1;
        for (int g = 0; g < vna_pkg::AXES; g++) begin
            w_center[g] = f_coord(i_in_data[vna_pkg::COORD_W*g +: vna_pkg::COORD_W]);
            w_first[g]  = f_coord(i_in_data[vna_pkg::COORD_W*(g+3) +: vna_pkg::COORD_W]);
            w_second[g] = f_coord(i_in_data[vna_pkg::COORD_W*(g+6) +: vna_pkg::COORD_W]);
            w_cmag[g]   = r_c[g][vna_pkg::CROSS_W-1] ? -r_c[g] : r_c[g];
            w_smag[g]   = r_sum[g][vna_pkg::SUM_W-1] ? -r_sum[g] : r_sum[g];
            w_cbig      = w_cbig | (|w_cmag[g][vna_pkg::CROSS_W-1:vna_pkg::SQ_W]);
            w_sbig      = w_sbig | (|w_smag[g][vna_pkg::SUM_W-1:vna_pkg::SQ_W]);
            w_t_hi      = w_t_hi | (|r_t[g][vna_pkg::SUM_W-1:vna_pkg::T_W]);
            w_t_lo      = w_t_lo & ~(|r_t[g][vna_pkg::SUM_W-1:vna_pkg::T_W-1]);
            w_sh[g]     = w_smag[g][vna_pkg::SUM_W-1:vna_pkg::RAW_SHIFT];
            w_raw_m[g]  = (w_sh[g] > SH_W'(vna_pkg::Q14_ONE)) ? vna_pkg::Q14_ONE
                                                              : w_sh[g][14:0];
        end
    end

    // squared-length tests against the thresholds
    assign w_face_exc = w_cbig ||
        (r_acc[vna_pkg::CHK_W-1:0] > {{(vna_pkg::CHK_W-vna_pkg::EPS_W){1'b0}}, r_face_eps});
    assign w_sum_exc  = w_sbig ||
        (r_acc[vna_pkg::CHK_W-1:0] > {{(vna_pkg::CHK_W-vna_pkg::EPS_W){1'b0}}, r_sum_eps});

    // multiplier operand select
    always_comb begin
        w_opa = '0;
        w_opb = '0;
        unique case (i_cmd.mop)
            vna_pkg::MOP_CX_P: begin
                w_opa = vna_pkg::OPND_W'(r_ea[1]);
                w_opb = vna_pkg::OPND_W'(r_eb[2]);
            end
            vna_pkg::MOP_CX_N: begin
                w_opa = -vna_pkg::OPND_W'(r_eb[1]);
                w_opb = vna_pkg::OPND_W'(r_ea[2]);
            end
            vna_pkg::MOP_CY_P: begin
                w_opa = vna_pkg::OPND_W'(r_ea[2]);
                w_opb = vna_pkg::OPND_W'(r_eb[0]);
            end
            vna_pkg::MOP_CY_N: begin
                w_opa = -vna_pkg::OPND_W'(r_ea[0]);
                w_opb = vna_pkg::OPND_W'(r_eb[2]);
            end
            vna_pkg::MOP_CZ_P: begin
                w_opa = vna_pkg::OPND_W'(r_ea[0]);
                w_opb = vna_pkg::OPND_W'(r_eb[1]);
            end
            vna_pkg::MOP_CZ_N: begin
                w_opa = -vna_pkg::OPND_W'(r_eb[0]);
                w_opb = vna_pkg::OPND_W'(r_ea[1]);
            end
            vna_pkg::MOP_CSQ: begin
                w_opa = {{(vna_pkg::OPND_W-vna_pkg::SQ_W){1'b0}},
                         w_cmag[i_cmd.idx][vna_pkg::SQ_W-1:0]};
                w_opb = w_opa;
            end
            vna_pkg::MOP_SSQ: begin
                w_opa = {{(vna_pkg::OPND_W-vna_pkg::SQ_W){1'b0}},
                         w_smag[i_cmd.idx][vna_pkg::SQ_W-1:0]};
                w_opb = w_opa;
            end
            vna_pkg::MOP_TSQ: begin
                w_opa = {{(vna_pkg::OPND_W-vna_pkg::T_W){1'b0}},
                         r_t[i_cmd.idx][vna_pkg::T_W-1:0]};
                w_opb = w_opa;
            end
            default: begin
                w_opa = '0;
                w_opb = '0;
            end
        endcase
    end

    // root step and divider step
    assign w_trial = r_res + r_bit;
    assign w_root  = r_res[vna_pkg::ROOT_W-1:0];
    assign w_num   = {{(vna_pkg::NUM_W-vna_pkg::T_W-15){1'b0}},
                      r_t[i_cmd.idx][vna_pkg::T_W-1:0], 15'b0}
                   + {{(vna_pkg::NUM_W-vna_pkg::ROOT_W){1'b0}}, w_root};
    assign w_rem2  = {r_rem, r_dn[vna_pkg::QUO_W-1]};
    assign w_div   = {{(vna_pkg::REM_W-vna_pkg::ROOT_W){1'b0}}, w_root, 1'b0};

    assign w_m_accept = r_out_valid & i_m_ready;

    // configuration, sums, pair count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_eps  <= '0;
            r_sum_eps   <= '0;
            r_sum[0]    <= '0;
            r_sum[1]    <= '0;
            r_sum[2]    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    vna_pkg::CFG_FACE_EPS: r_face_eps <= i_cfg_data;
                    vna_pkg::CFG_SUM_EPS:  r_sum_eps  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_m_accept) r_out_valid <= 1'b0;
            if (i_cmd.op == vna_pkg::DP_ACCUM) begin
                r_count <= r_count + 1'b1;
                if (w_face_exc) begin
                    for (int g = 0; g < vna_pkg::AXES; g++)
                        r_sum[g] <= r_sum[g] + vna_pkg::SUM_W'(r_c[g]);
                end
            end else if (i_cmd.op == vna_pkg::DP_EMIT) begin
                r_sum[0]    <= '0;
                r_sum[1]    <= '0;
                r_sum[2]    <= '0;
                r_count     <= '0;
                r_out_valid <= 1'b1;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            vna_pkg::DP_LOAD: begin
                for (int g = 0; g < vna_pkg::AXES; g++) begin
                    r_ea[g] <= w_first[g] - w_center[g];
                    r_eb[g] <= w_second[g] - w_center[g];
                end
                r_pv   <= i_in_pair_valid;
                r_last <= i_in_last;
                r_acc  <= '0;
            end
            vna_pkg::DP_MUL: r_prod <= w_opa * w_opb;
            vna_pkg::DP_ADD: r_acc  <= r_acc + vna_pkg::ACC_W'(r_prod);
            vna_pkg::DP_STC: begin
                r_c[i_cmd.idx] <= r_acc[vna_pkg::CROSS_W-1:0];
                r_acc          <= '0;
            end
            vna_pkg::DP_ORIENT: begin
                if (r_c[1][vna_pkg::CROSS_W-1]) begin
                    for (int g = 0; g < vna_pkg::AXES; g++) r_c[g] <= -r_c[g];
                end
            end
            vna_pkg::DP_ACCUM: r_acc <= '0;
            vna_pkg::DP_LOAD_T: begin
                for (int g = 0; g < vna_pkg::AXES; g++) r_t[g] <= w_smag[g];
                r_acc <= '0;
                r_nrm <= 1'b1;
            end
            vna_pkg::DP_RAW: r_nrm <= 1'b0;
            vna_pkg::DP_SHR: begin
                for (int g = 0; g < vna_pkg::AXES; g++) r_t[g] <= r_t[g] >> 1;
            end
            vna_pkg::DP_SHL: begin
                for (int g = 0; g < vna_pkg::AXES; g++) r_t[g] <= r_t[g] << 1;
            end
            vna_pkg::DP_SQINIT: begin
                r_sn  <= r_acc[vna_pkg::RN_W-1:0];
                r_res <= '0;
                r_bit <= {2'b01, {(vna_pkg::RN_W-2){1'b0}}};
            end
            vna_pkg::DP_SQSTEP: begin
                if (r_sn >= w_trial) begin
                    r_sn  <= r_sn - w_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            vna_pkg::DP_DINIT: begin
                r_rem <= vna_pkg::REM_W'(w_num[vna_pkg::NUM_W-1:vna_pkg::QUO_W]);
                r_dn  <= w_num[vna_pkg::QUO_W-1:0];
                r_quo <= '0;
            end
            vna_pkg::DP_DSTEP: begin
                if (w_rem2 >= w_div) begin
                    r_rem <= vna_pkg::REM_W'(w_rem2 - w_div);
                    r_quo <= {r_quo[vna_pkg::QUO_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_rem2[vna_pkg::REM_W-1:0];
                    r_quo <= {r_quo[vna_pkg::QUO_W-2:0], 1'b0};
                end
                r_dn <= r_dn << 1;
            end
            vna_pkg::DP_DSTORE: begin
                r_q[i_cmd.idx] <= (r_quo > vna_pkg::QUO_W'(vna_pkg::Q14_ONE))
                                ? vna_pkg::Q14_ONE : r_quo[14:0];
            end
            vna_pkg::DP_EMIT: begin
                for (int g = 0; g < vna_pkg::AXES; g++) begin
                    r_out_data[vna_pkg::OUT_W*g +: vna_pkg::OUT_W] <=
                        f_signed_out(r_sum[g][vna_pkg::SUM_W-1], r_nrm ? r_q[g] : w_raw_m[g]);
                end
                r_out_nrm <= r_nrm;
            end
            default: ;
        endcase
    end

    // status to the controller
    assign o_status.pair_valid = r_pv;
    assign o_status.last_pair  = r_last;
    assign o_status.count_ok   = (r_count < CNT_W'(MAX_PAIRS));
    assign o_status.sum_exc    = w_sum_exc;
    assign o_status.t_hi       = w_t_hi;
    assign o_status.t_lo       = w_t_lo;
    assign o_status.out_full   = r_out_valid;

    assign o_m_valid      = r_out_valid;
    assign o_m_data       = r_out_data;
    assign o_m_normalized = r_out_nrm;

endmodule

`default_nettype wire

/* hdl/vna_checker.sv */
// ----------------------------------------------------------------------------
// Vertex normal accumulator port checker
// Port-level properties on the stream handshakes and result range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "vertex_normal_accumulator_macros.svh"

module vna_checker (
    input wire                                i_clk,
    input wire                                i_rst_n,
    input wire                                s_axis_tvalid,
    input wire                                s_axis_tready,
    input wire                                m_axis_tvalid,
    input wire                                m_axis_tready,
    input wire [vna_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    // a stalled result stays offered and unchanged
    `VNA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `VNA_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

    // each accepted pair leaves the block busy in the following cycle
    `VNA_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // every component stays within Q1.14 unit range
    `VNA_ASSERT_SAME(a_out_range, m_axis_tvalid, ($signed(m_axis_tdata[15:0]) >= -16'sd16384) && ($signed(m_axis_tdata[15:0]) <= 16'sd16384) && ($signed(m_axis_tdata[31:16]) >= -16'sd16384) && ($signed(m_axis_tdata[31:16]) <= 16'sd16384) && ($signed(m_axis_tdata[47:32]) >= -16'sd16384) && ($signed(m_axis_tdata[47:32]) <= 16'sd16384))

endmodule

bind vertex_normal_accumulator vna_checker u_vna_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
